// ----- rtl/tcpoa_pkg.sv -----
package tcpoa_pkg;

  // walk phases
  localparam logic [2:0] PhDone      = 3'd0;
  localparam logic [2:0] PhKind      = 3'd1;
  localparam logic [2:0] PhSizeOther = 3'd2;
  localparam logic [2:0] PhSkip      = 3'd3;
  localparam logic [2:0] PhCapture   = 3'd4;
  localparam logic [2:0] PhSizeMatch = 3'd5;

  // result status codes
  localparam logic [2:0] StFound     = 3'd0;
  localparam logic [2:0] StEol       = 3'd1;
  localparam logic [2:0] StSilly     = 3'd2;
  localparam logic [2:0] StPartial   = 3'd3;
  localparam logic [2:0] StExhausted = 3'd4;

  // option codes and sizes
  localparam logic [7:0] OptEol       = 8'd0;
  localparam logic [7:0] OptNop       = 8'd1;
  localparam logic [7:0] AddrOptSize  = 8'd8;
  localparam logic [5:0] AddrPayload  = 6'd6;
  localparam logic [7:0] MinOptSize   = 8'd2;
  localparam logic [3:0] BaseHdrWords = 4'd5;
  localparam logic [5:0] BaseHdrBytes = 6'd20;
  localparam logic [7:0] KindReset    = 8'd254;

  typedef struct packed {
    logic        found;
    logic [2:0]  status;
    logic [15:0] client_port;
    logic [31:0] client_ip;
  } result_t;

  typedef struct packed {
    logic       func;
    logic [3:0] header_words;
    logic [7:0] opt_byte;
  } item_t;

endpackage

// ----- rtl/tcpoa_walk.sv -----
module tcpoa_walk (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             advance_i,
  input  tcpoa_pkg::item_t item_i,
  input  logic [7:0]       kind_i,
  output logic             emit_o,
  output tcpoa_pkg::result_t result_o
);
  import tcpoa_pkg::*;

  logic [2:0]  phase_q, phase_d;
  logic [5:0]  left_q, left_d;
  logic [5:0]  step_q, step_d;
  logic [47:0] cap_q, cap_d;

  logic [5:0]  left_n;
  logic [5:0]  step_n;
  logic [47:0] cap_n;

  always_comb begin
    phase_d  = phase_q;
    left_d   = left_q;
    step_d   = step_q;
    cap_d    = cap_q;
    emit_o   = 1'b0;
    result_o = '0;
    result_o.status = StExhausted;
    left_n   = left_q - {5'd0, 1'b1};
    step_n   = step_q - {5'd0, 1'b1};
    cap_n    = {cap_q[39:0], item_i.opt_byte};

    if (!item_i.func) begin
      cap_d  = '0;
      step_d = '0;
      if (item_i.header_words <= BaseHdrWords) begin
        left_d  = '0;
        emit_o  = 1'b1;
        phase_d = PhDone;
      end else begin
        left_d  = {item_i.header_words, 2'b00} - BaseHdrBytes;
        phase_d = PhKind;
      end
    end else begin
      unique case (phase_q)
        PhKind: begin
          if (item_i.opt_byte == OptEol) begin
            emit_o          = 1'b1;
            result_o.status = StEol;
            phase_d         = PhDone;
          end else if (item_i.opt_byte == OptNop) begin
            left_d = left_n;
            if (left_n == '0) begin
              emit_o  = 1'b1;
              phase_d = PhDone;
            end
          end else begin
            phase_d = (item_i.opt_byte == kind_i) ? PhSizeMatch : PhSizeOther;
          end
        end
        PhSizeOther, PhSizeMatch: begin
          left_n = left_q - item_i.opt_byte[5:0];
          step_n = item_i.opt_byte[5:0] - MinOptSize[5:0];
          if (item_i.opt_byte < MinOptSize) begin
            emit_o          = 1'b1;
            result_o.status = StSilly;
            phase_d         = PhDone;
          end else if (item_i.opt_byte > {2'b00, left_q}) begin
            emit_o          = 1'b1;
            result_o.status = StPartial;
            phase_d         = PhDone;
          end else if (phase_q == PhSizeMatch && item_i.opt_byte == AddrOptSize) begin
            cap_d   = '0;
            step_d  = AddrPayload;
            phase_d = PhCapture;
          end else begin
            left_d = left_n;
            step_d = step_n;
            if (step_n != '0) begin
              phase_d = PhSkip;
            end else if (left_n == '0) begin
              emit_o  = 1'b1;
              phase_d = PhDone;
            end else begin
              phase_d = PhKind;
            end
          end
        end
        PhSkip: begin
          step_d = step_n;
          if (step_n == '0) begin
            if (left_q == '0) begin
              emit_o  = 1'b1;
              phase_d = PhDone;
            end else begin
              phase_d = PhKind;
            end
          end
        end
        PhCapture: begin
          cap_d  = cap_n;
          step_d = step_n;
          if (step_n == '0) begin
            emit_o               = 1'b1;
            result_o.found       = 1'b1;
            result_o.status      = StFound;
            result_o.client_port = cap_n[47:32];
            result_o.client_ip   = cap_n[31:0];
            phase_d              = PhDone;
          end
        end
        default: begin
          // idle: stray option bytes are dropped
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhDone;
      left_q  <= '0;
      step_q  <= '0;
      cap_q   <= '0;
    end else if (advance_i) begin
      phase_q <= phase_d;
      left_q  <= left_d;
      step_q  <= step_d;
      cap_q   <= cap_d;
    end
  end

endmodule

// ----- rtl/tcp_option_address_extract.sv -----
// tcp option walk with address option capture
// result: registered from the item register into the output register as the walk ends
// throughput: one item per cycle; an item that ends a walk waits while a result is stalled
// reset: asynchronous active low; walk idle, counters and capture cleared,
// option kind register set to 254
module tcp_option_address_extract (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [3:0]  header_words_i,
  input  logic [7:0]  opt_byte_i,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        found_o,
  output logic [2:0]  status_o,
  output logic [15:0] client_port_o,
  output logic [31:0] client_ip_o
);
  import tcpoa_pkg::*;

  logic    kind_we;
  logic [7:0] kind_q;

  logic    in_valid_q, in_valid_d;
  item_t   item_q;
  logic    accept;
  logic    advance;
  logic    emit;
  logic    out_free;
  result_t result;

  logic    out_valid_q, out_valid_d;
  result_t out_q;

  assign kind_we = cfg_we_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= KindReset;
    end else if (kind_we) begin
      kind_q <= cfg_data_i;
    end
  end

  // an item holds in the input register only when it would emit into a stalled output
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && (!emit || out_free);
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.func         <= func_i;
      item_q.header_words <= header_words_i;
      item_q.opt_byte     <= opt_byte_i;
    end
  end

  tcpoa_walk u_walk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (item_q),
    .kind_i    (kind_q),
    .emit_o    (emit),
    .result_o  (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance && emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_q <= result;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = out_q.found;
  assign status_o      = out_q.status;
  assign client_port_o = out_q.client_port;
  assign client_ip_o   = out_q.client_ip;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import tcpoa_pkg::*;

  localparam int HoldCycles   = 80;
  localparam int SettleCycles = 6;
  localparam int IdleLimit    = 1000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        func = 1'b0;
  logic [3:0]  header_words = '0;
  logic [7:0]  opt_byte = '0;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        found;
  logic [2:0]  status;
  logic [15:0] client_port;
  logic [31:0] client_ip;

  // walk state mirrored from the block
  logic [7:0]  addr_kind = KindReset;
  logic [2:0]  walk_phase = PhDone;
  logic [5:0]  bytes_left = '0;
  logic [5:0]  step_cnt = '0;
  logic [47:0] cap_buf = '0;

  result_t     walk_outcomes[$];
  int          mismatch_count = 0;
  int          items_sent = 0;
  bit          in_gaps_on = 1'b0;
  bit          out_gaps_on = 1'b0;
  bit          hold_req = 1'b0;

  tcp_option_address_extract i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .func_i         (func),
    .header_words_i (header_words),
    .opt_byte_i     (opt_byte),
    .cfg_we_i       (cfg_we),
    .cfg_data_i     (cfg_data),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .found_o        (found),
    .status_o       (status),
    .client_port_o  (client_port),
    .client_ip_o    (client_ip)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic close_walk(input logic [2:0] st);
    result_t r;
    r = '0;
    r.status = st;
    walk_outcomes.push_back(r);
    walk_phase = PhDone;
  endtask

  task automatic advance_option_walk(input logic f, input logic [3:0] w, input logic [7:0] b);
    result_t r;
    if (!f) begin
      cap_buf = '0;
      step_cnt = '0;
      if (w <= BaseHdrWords) begin
        bytes_left = '0;
        close_walk(StExhausted);
      end else begin
        bytes_left = {w, 2'b00} - BaseHdrBytes;
        walk_phase = PhKind;
      end
    end else begin
      case (walk_phase)
        PhKind: begin
          if (b == OptEol) begin
            close_walk(StEol);
          end else if (b == OptNop) begin
            bytes_left = bytes_left - 6'd1;
            if (bytes_left == 0) close_walk(StExhausted);
          end else begin
            walk_phase = (b == addr_kind) ? PhSizeMatch : PhSizeOther;
          end
        end
        PhSizeOther, PhSizeMatch: begin
          if (b < MinOptSize) begin
            close_walk(StSilly);
          end else if (b > {2'b00, bytes_left}) begin
            close_walk(StPartial);
          end else if (walk_phase == PhSizeMatch && b == AddrOptSize) begin
            cap_buf = '0;
            step_cnt = AddrPayload;
            walk_phase = PhCapture;
          end else begin
            // size fits in the area here, so six bits hold it
            bytes_left = bytes_left - b[5:0];
            step_cnt = b[5:0] - 6'd2;
            if (step_cnt != 0) walk_phase = PhSkip;
            else if (bytes_left == 0) close_walk(StExhausted);
            else walk_phase = PhKind;
          end
        end
        PhSkip: begin
          step_cnt = step_cnt - 6'd1;
          if (step_cnt == 0) begin
            if (bytes_left == 0) close_walk(StExhausted);
            else walk_phase = PhKind;
          end
        end
        PhCapture: begin
          cap_buf = {cap_buf[39:0], b};
          step_cnt = step_cnt - 6'd1;
          if (step_cnt == 0) begin
            r.found = 1'b1;
            r.status = StFound;
            r.client_port = cap_buf[47:32];
            r.client_ip = cap_buf[31:0];
            walk_outcomes.push_back(r);
            walk_phase = PhDone;
          end
        end
        default: begin
          // byte with no walk open is dropped
        end
      endcase
    end
  endtask

  // leaves valid high so a following item goes out back to back
  task automatic send_item(input logic f, input logic [3:0] w, input logic [7:0] b);
    int gap;
    if (in_gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    func         <= f;
    header_words <= w;
    opt_byte     <= b;
    do @(posedge clk); while (in_stall);
    items_sent++;
    advance_option_walk(f, w, b);
  endtask

  task automatic send_byte(input logic [7:0] b);
    logic [31:0] rnd;
    rnd = $urandom();
    send_item(1'b1, rnd[3:0], b);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (walk_outcomes.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_option_kind(input logic [7:0] k);
    wait_drained();
    cfg_we   <= 1'b1;
    cfg_data <= k;
    @(posedge clk);
    addr_kind = k;
    cfg_we <= 1'b0;
  endtask

  task automatic send_random_segment();
    logic [31:0] rnd;
    logic [3:0]  w;
    int          left;
    int          sz;
    int          pick;
    rnd = $urandom();
    if ($urandom_range(0, 19) == 0) begin
      // noise: any func, any fields
      send_item(rnd[0], rnd[4:1], rnd[12:5]);
      return;
    end
    if ($urandom_range(0, 9) == 0) w = 4'($urandom_range(0, 5));
    else w = 4'($urandom_range(6, 15));
    send_item(1'b0, w, rnd[7:0]);
    left = (w > BaseHdrWords) ? w * 4 - 20 : 0;
    while (left > 0) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        send_byte(OptNop);
        left--;
      end else if (pick < 22) begin
        send_byte(OptEol);
        left = 0;
      end else if (pick < 50 && left >= 8) begin
        send_byte(addr_kind);
        send_byte(AddrOptSize);
        repeat (AddrPayload) send_byte(8'($urandom()));
        left = 0;
      end else if (pick < 56) begin
        // malformed size: below two or past the area end
        send_byte(8'($urandom_range(2, 255)));
        if (pick[0]) send_byte(8'($urandom_range(0, 1)));
        else send_byte(8'(left + $urandom_range(1, 20)));
        left = 0;
      end else if (pick < 59) begin
        // walk left open, the next start cuts it off
        left = 0;
      end else begin
        send_byte(8'($urandom_range(2, 255)));
        if (left < 2) begin
          send_byte(8'($urandom()));
          left = 0;
        end else begin
          sz = $urandom_range(2, (left < 12) ? left : 12);
          send_byte(8'(sz));
          repeat (sz - 2) send_byte(8'($urandom()));
          left -= sz;
        end
      end
    end
  endtask

  task automatic test_empty_area();
    send_item(1'b0, 4'd0, 8'hff);
    send_item(1'b1, 4'd15, 8'hff);
    send_item(1'b0, BaseHdrWords, 8'h00);
  endtask

  task automatic test_address_capture();
    send_item(1'b0, 4'd7, 8'h00);
    send_byte(KindReset);
    send_byte(AddrOptSize);
    send_byte(8'hff);
    send_byte(8'h00);
    send_byte(8'haa);
    send_byte(8'h55);
    send_byte(8'h01);
    send_byte(8'h80);
  endtask

  task automatic test_walk_endings();
    send_item(1'b0, 4'd15, 8'h00);
    send_byte(OptEol);
    // kind in the last area byte, size then overruns
    send_item(1'b0, 4'd6, 8'h00);
    send_byte(OptNop);
    send_byte(OptNop);
    send_byte(OptNop);
    send_byte(8'd7);
    send_byte(MinOptSize);
    send_item(1'b0, 4'd6, 8'h00);
    send_byte(8'd3);
    send_byte(8'd1);
  endtask

  task automatic test_restart();
    send_item(1'b0, 4'd6, 8'h00);
    send_byte(OptNop);
    send_item(1'b0, 4'd6, 8'h00);
    send_byte(8'd9);
    send_byte(8'd4);
    send_byte(8'h5a);
    send_byte(8'ha5);
  endtask

  task automatic test_random_walks(input logic [7:0] kind, input int n_items,
                                   input bit gaps, input bit hold);
    int stop_at;
    write_option_kind(kind);
    in_gaps_on  = gaps;
    out_gaps_on = gaps;
    if (hold) hold_req = 1'b1;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) send_random_segment();
    // close any walk still open before the next register write
    send_item(1'b0, 4'd0, 8'h00);
    wait_drained();
  endtask

  initial begin : result_stall
    int n;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        out_stall <= 1'b0;
      end else if (out_gaps_on && $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 6);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (out_valid && !out_stall) begin
      if (walk_outcomes.size() == 0) begin
        report_mismatch($sformatf("result with none pending, status %0d", status));
      end else begin
        want = walk_outcomes.pop_front();
        if (found !== want.found)
          report_mismatch($sformatf("found %0b expected %0b", found, want.found));
        if (status !== want.status)
          report_mismatch($sformatf("status %0d expected %0d", status, want.status));
        if (client_port !== want.client_port)
          report_mismatch($sformatf("client_port %h expected %h",
                                    client_port, want.client_port));
        if (client_ip !== want.client_ip)
          report_mismatch($sformatf("client_ip %h expected %h", client_ip, want.client_ip));
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IdleLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : run_tests
    logic [7:0] rand_kind;
    rand_kind = 8'($urandom_range(2, 253));
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    in_gaps_on  = 1'b1;
    out_gaps_on = 1'b1;
    test_empty_area();
    test_address_capture();
    test_walk_endings();
    test_restart();
    test_random_walks(8'd255, 110, 1'b1, 1'b1);
    test_random_walks(OptEol, 60, 1'b1, 1'b0);
    test_random_walks(OptNop, 60, 1'b1, 1'b0);
    test_random_walks(rand_kind, 120, 1'b1, 1'b0);
    test_random_walks(KindReset, 150, 1'b0, 1'b0);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/tcpoa_pkg.sv
rtl/tcpoa_walk.sv
rtl/tcp_option_address_extract.sv
tb/testbench.sv
